### design/nsr_pkg.sv
// Shared types and constants for the NMEA sentence receiver.
// Holds byte classes, queue entry layout, event codes and result field offsets.
// No dependencies.
package nsr_pkg;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam int unsigned HEX_SHIFT  = 4;   // first digit weight of 16

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int unsigned FIELD_W  = 6;
    localparam int unsigned POS_W    = 7;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned EVENT_W  = 3;

    // Result tdata layout, lowest bit first
    localparam int unsigned OFS_CHAR  = 0;
    localparam int unsigned OFS_POS   = OFS_CHAR + 8;
    localparam int unsigned OFS_FIELD = OFS_POS + POS_W;
    localparam int unsigned OFS_RSUM  = OFS_FIELD + FIELD_W;
    localparam int unsigned OFS_CSUM  = OFS_RSUM + 8;
    localparam int unsigned OFS_GOOD  = OFS_CSUM + 8;
    localparam int unsigned RES_BITS  = OFS_GOOD + COUNT_W;
    localparam int unsigned RES_W     = ((RES_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_BODY = 2'd1,
        PH_SUM1 = 2'd2,
        PH_SUM2 = 2'd3
    } phase_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_START  = 3'd0,
        EV_BYTE   = 3'd1,
        EV_GOOD   = 3'd2,
        EV_BAD    = 3'd3,
        EV_FIELDS = 3'd4,
        EV_LENGTH = 3'd5,
        EV_BOTH   = 3'd6
    } event_t;

    typedef enum logic [1:0] {
        KIND_OTHER  = 2'd0,
        KIND_DOLLAR = 2'd1,
        KIND_STAR   = 2'd2,
        KIND_COMMA  = 2'd3
    } kind_t;

    typedef enum logic [0:0] {
        REG_MAX_FIELDS = 1'd0,
        REG_MAX_LENGTH = 1'd1
    } reg_index_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic [3:0] hex;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    typedef struct packed {
        logic [FIELD_W-1:0] max_fields;
        logic [POS_W-1:0]   max_length;
    } cfg_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            v = c[3:0] + 4'd9;
        return v;
    endfunction

endpackage

### design/nmea_sentence_receiver.sv
// Top level of the NMEA 0183 sentence receiver with XOR checksum check.
// Depends on nsr_pkg, nsr_front, nsr_queue and nsr_framer.
//
// Usage:
//   s_ channel: one received byte per transaction, s_tdata[7:0].
//   m_ channel: one event per transaction, kind on m_tuser, details on m_tdata.
//     Bytes outside a sentence, the '*' and the first checksum digit produce
//     no transaction; every other byte produces exactly one.
//   cfg port: cfg_we writes cfg_wdata to register cfg_addr (0 max_fields,
//     1 max_length) on the clock edge; write only while the block is idle.
// An accepted byte is written into the queue, read from it by the framer and then
//   shows its event on m_ from the framer's result register.
// Throughput: one byte per cycle while m_tready is high, set by the framer's
//   sentence-state update; a 4-entry queue decouples input from the framer.
// Stall: while a result waits with m_tready low the framer holds it and stops
//   reading the queue; s_tready drops once the queue has filled.
// Reset (aresetn low, synchronous): framer waits for '$', counters and the
//   checksum clear, the queue empties, registers return to 24 and 82.
module nmea_sentence_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] body_char, [14:8] position, [20:15] field_index,
    // [28:21] received_sum, [36:29] computed_sum, [68:37] good_count, zero pad
    output logic [nsr_pkg::RES_W-1:0]   m_tdata,
    output logic [nsr_pkg::EVENT_W-1:0] m_tuser,   // [2:0] event_res
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [6:0]  cfg_wdata
);
    import nsr_pkg::*;

    cfg_t           cfg_reg, cfg_next;
    queue_status_t  q_status;
    logic           push, pop;
    entry_t         push_entry, pop_entry;

    // Configuration registers: hold unless written
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (reg_index_t'(cfg_addr))
                REG_MAX_FIELDS: cfg_next.max_fields = cfg_wdata[FIELD_W-1:0];
                REG_MAX_LENGTH: cfg_next.max_length = cfg_wdata[POS_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_fields <= FIELD_W'(24);
            cfg_reg.max_length <= POS_W'(82);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: classify and enqueue
    nsr_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    nsr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .status     (q_status)
    );

    // Back end: advance the sentence and register the result
    nsr_framer u_framer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .q_status   (q_status),
        .pop_entry  (pop_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    // A start event always reports an empty sentence
    a_start_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == EV_START) |->
            (m_tdata[OFS_FIELD +: FIELD_W] == '0 && m_tdata[OFS_POS +: POS_W] == '0
             && m_tdata[OFS_CSUM +: 8] == '0))
        else $error("start event with nonzero sentence state");

    // A plain body byte never reaches the field limit
    a_byte_in_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == EV_BYTE) |->
            (m_tdata[OFS_FIELD +: FIELD_W] < cfg_reg.max_fields))
        else $error("body byte reported past the field limit");

    // Input stalls only when the queue is full
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (q_status.full && !q_status.empty))
        else $error("input stalled with room in the queue");

    // The framer never reads an empty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("framer read an empty queue");

endmodule

### design/nsr_front.sv
// Front end: takes received bytes and classifies them for the framer.
// Depends on nsr_pkg.
module nsr_front (
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,   // [7:0] rx_byte
    input  nsr_pkg::queue_status_t q_status,
    output logic            push,
    output nsr_pkg::entry_t push_entry
);
    import nsr_pkg::*;

    assign s_tready = !q_status.full;
    assign push     = s_tvalid && !q_status.full;

    always_comb begin
        push_entry.data = s_tdata;
        push_entry.hex  = hex_value(s_tdata);
        priority if (s_tdata == CHAR_DOLLAR) push_entry.kind = KIND_DOLLAR;
        else if (s_tdata == CHAR_STAR)       push_entry.kind = KIND_STAR;
        else if (s_tdata == CHAR_COMMA)      push_entry.kind = KIND_COMMA;
        else                                 push_entry.kind = KIND_OTHER;
    end

endmodule

### design/nsr_queue.sv
// Short FIFO of classified bytes between front end and framer.
// Depends on nsr_pkg.
module nsr_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  nsr_pkg::entry_t push_entry,
    input  logic            pop,
    output nsr_pkg::entry_t pop_entry,
    output nsr_pkg::queue_status_t status
);
    import nsr_pkg::*;

    entry_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_entry    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) count_next = count_reg + 1'b1;
        else if (!do_push && do_pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/nsr_framer.sv
// Back end: sentence state machine, checksum, limits and result register.
// Depends on nsr_pkg.
module nsr_framer (
    input  logic            aclk,
    input  logic            aresetn,
    input  nsr_pkg::cfg_t   cfg,
    input  nsr_pkg::queue_status_t q_status,
    input  nsr_pkg::entry_t pop_entry,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [nsr_pkg::RES_W-1:0]   m_tdata,
    output logic [nsr_pkg::EVENT_W-1:0] m_tuser
);
    import nsr_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [POS_W-1:0]    wpos_reg, wpos_next;
    logic [FIELD_W-1:0]  fcnt_reg, fcnt_next;
    logic [7:0]          rsum_reg, rsum_next;
    logic [7:0]          sread_reg, sread_next;
    logic [COUNT_W-1:0]  total_reg, total_next;

    logic                valid_reg, valid_next;
    event_t              ev_reg, ev_next;
    logic [7:0]          char_reg, char_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [FIELD_W-1:0]  fld_reg, fld_next;
    logic [7:0]          rs_reg, rs_next;
    logic [7:0]          cs_reg, cs_next;
    logic [COUNT_W-1:0]  good_reg, good_next;

    logic                emit;
    logic [7:0]          sum_full;
    logic                over_f, over_l;

    // Take a byte whenever the result register is free or being drained
    assign pop = !q_status.empty && (!valid_reg || m_tready);

    always_comb begin
        phase_next = phase_reg;
        wpos_next  = wpos_reg;
        fcnt_next  = fcnt_reg;
        rsum_next  = rsum_reg;
        sread_next = sread_reg;
        total_next = total_reg;
        emit       = 1'b0;
        ev_next    = ev_reg;
        char_next  = char_reg;
        pos_next   = pos_reg;
        fld_next   = fld_reg;
        rs_next    = rs_reg;
        sum_full   = sread_reg + {4'd0, pop_entry.hex};
        over_f     = 1'b0;
        over_l     = 1'b0;

        if (pop) begin
            unique case (phase_reg)
                PH_WAIT, PH_BODY: begin
                    if (pop_entry.kind == KIND_DOLLAR) begin
                        wpos_next  = POS_W'(1);
                        fcnt_next  = '0;
                        rsum_next  = '0;
                        phase_next = PH_BODY;
                        emit       = 1'b1;
                        ev_next    = EV_START;
                        char_next  = CHAR_DOLLAR;
                        pos_next   = '0;
                        fld_next   = '0;
                        rs_next    = '0;
                    end else if (phase_reg == PH_BODY) begin
                        if (pop_entry.kind == KIND_STAR) begin
                            fcnt_next  = fcnt_reg + 1'b1;
                            phase_next = PH_SUM1;
                        end else begin
                            rsum_next = rsum_reg ^ pop_entry.data;
                            if (pop_entry.kind == KIND_COMMA)
                                fcnt_next = fcnt_reg + 1'b1;
                            wpos_next = wpos_reg + 1'b1;
                            over_f    = fcnt_next >= cfg.max_fields;
                            over_l    = wpos_next >= cfg.max_length;
                            emit      = 1'b1;
                            priority if (over_f && over_l) ev_next = EV_BOTH;
                            else if (over_f)               ev_next = EV_FIELDS;
                            else if (over_l)               ev_next = EV_LENGTH;
                            else                           ev_next = EV_BYTE;
                            if (over_f || over_l) phase_next = PH_WAIT;
                            char_next = (pop_entry.kind == KIND_COMMA) ? 8'd0
                                                                        : pop_entry.data;
                            pos_next  = wpos_reg;
                            fld_next  = fcnt_next;
                            rs_next   = '0;
                        end
                    end
                end
                PH_SUM1: begin
                    sread_next = {4'd0, pop_entry.hex} << HEX_SHIFT;
                    phase_next = PH_SUM2;
                end
                PH_SUM2: begin
                    sread_next = sum_full;
                    phase_next = PH_WAIT;
                    emit       = 1'b1;
                    if (sum_full == rsum_reg) begin
                        total_next = total_reg + 1'b1;
                        ev_next    = EV_GOOD;
                    end else begin
                        ev_next    = EV_BAD;
                    end
                    char_next = '0;
                    pos_next  = wpos_reg;
                    fld_next  = fcnt_reg;
                    rs_next   = sum_full;
                end
                default: phase_next = PH_WAIT;
            endcase
        end

        cs_next    = rsum_next;
        good_next  = total_next;
        if (emit)          valid_next = 1'b1;
        else if (m_tready) valid_next = 1'b0;
        else               valid_next = valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WAIT;
            wpos_reg  <= '0;
            fcnt_reg  <= '0;
            rsum_reg  <= '0;
            sread_reg <= '0;
            total_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            wpos_reg  <= wpos_next;
            fcnt_reg  <= fcnt_next;
            rsum_reg  <= rsum_next;
            sread_reg <= sread_next;
            total_reg <= total_next;
            valid_reg <= valid_next;
        end
    end

    // Result payload, loaded only with a new result
    always_ff @(posedge aclk) begin
        if (emit) begin
            ev_reg   <= ev_next;
            char_reg <= char_next;
            pos_reg  <= pos_next;
            fld_reg  <= fld_next;
            rs_reg   <= rs_next;
            cs_reg   <= cs_next;
            good_reg <= good_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = ev_reg;
    assign m_tdata  = {(RES_W - RES_BITS)'(0), good_reg, cs_reg, rs_reg,
                       fld_reg, pos_reg, char_reg};

endmodule

### test/sentence_event_checker.sv
// Watches both streams of nmea_sentence_receiver, predicts each event and compares it.
// Depends on nsr_pkg for event, phase and register codes and the result layout.
module sentence_event_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [7:0]                  s_tdata,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [nsr_pkg::RES_W-1:0]   m_tdata,
    input  logic [nsr_pkg::EVENT_W-1:0] m_tuser,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_addr,
    input  logic [6:0]                  cfg_wdata,
    output int unsigned                 mismatches,
    output int unsigned                 awaited
);
    import nsr_pkg::*;

    typedef struct packed {
        event_t      ev;
        logic [7:0]  ch;
        logic [6:0]  pos;
        logic [5:0]  fld;
        logic [7:0]  rsum;
        logic [7:0]  csum;
        logic [31:0] good;
    } sentence_event_t;

    sentence_event_t expected_events[$];
    sentence_event_t oldest;

    logic [5:0]  lim_fields;
    logic [6:0]  lim_length;
    phase_t      fr_phase;
    logic [6:0]  fr_pos;
    logic [5:0]  fr_fields;
    logic [7:0]  fr_xor;
    logic [7:0]  fr_digits;
    logic [31:0] fr_good;

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) d = c - 8'h30;
        else if (c >= 8'h41 && c <= 8'h46) d = c - 8'h37;
        else if (c >= 8'h61 && c <= 8'h66) d = c - 8'h57;
        return d[3:0];
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, seen);
        end
    endtask

    // Advance the sentence state by one byte and queue the event it causes, if any.
    task automatic frame_byte(input logic [7:0] b);
        sentence_event_t e;
        logic over_f, over_l;
        e = '0;
        case (fr_phase)
            PH_WAIT, PH_BODY: begin
                if (b == CHAR_DOLLAR) begin
                    fr_pos    = 7'd1;
                    fr_fields = 6'd0;
                    fr_xor    = 8'h00;
                    fr_phase  = PH_BODY;
                    e.ev   = EV_START;
                    e.ch   = CHAR_DOLLAR;
                    e.good = fr_good;
                    expected_events.push_back(e);
                end else if (fr_phase == PH_BODY) begin
                    if (b == CHAR_STAR) begin
                        fr_fields = fr_fields + 6'd1;
                        fr_phase  = PH_SUM1;
                    end else begin
                        e.ch  = b;
                        e.pos = fr_pos;
                        fr_xor = fr_xor ^ b;
                        if (b == CHAR_COMMA) begin
                            e.ch      = 8'h00;
                            fr_fields = fr_fields + 6'd1;
                        end
                        fr_pos = fr_pos + 7'd1;
                        over_f = fr_fields >= lim_fields;
                        over_l = fr_pos >= lim_length;
                        if (over_f && over_l) e.ev = EV_BOTH;
                        else if (over_f) e.ev = EV_FIELDS;
                        else if (over_l) e.ev = EV_LENGTH;
                        else e.ev = EV_BYTE;
                        if (e.ev != EV_BYTE) fr_phase = PH_WAIT;
                        e.fld  = fr_fields;
                        e.csum = fr_xor;
                        e.good = fr_good;
                        expected_events.push_back(e);
                    end
                end
            end
            PH_SUM1: begin
                fr_digits = {digit_value(b), 4'h0};
                fr_phase  = PH_SUM2;
            end
            default: begin
                fr_digits = fr_digits + {4'h0, digit_value(b)};
                fr_phase  = PH_WAIT;
                if (fr_digits == fr_xor) begin
                    fr_good = fr_good + 32'd1;
                    e.ev    = EV_GOOD;
                end else begin
                    e.ev = EV_BAD;
                end
                e.pos  = fr_pos;
                e.fld  = fr_fields;
                e.rsum = fr_digits;
                e.csum = fr_xor;
                e.good = fr_good;
                expected_events.push_back(e);
            end
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            mismatches = 0;
            lim_fields = 6'd24;
            lim_length = 7'd82;
            fr_phase   = PH_WAIT;
            fr_pos     = 7'd0;
            fr_fields  = 6'd0;
            fr_xor     = 8'h00;
            fr_digits  = 8'h00;
            fr_good    = 32'd0;
            expected_events.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_MAX_FIELDS: lim_fields = cfg_wdata[5:0];
                    default:        lim_length = cfg_wdata;
                endcase
            end
            // results leave before the byte of this edge can have any effect
            if (m_tvalid && m_tready) begin
                if (expected_events.size() == 0) begin
                    mismatches++;
                    $display("%0t: event %0d with nothing expected, expected none, actual %h",
                             $time, m_tuser, m_tdata);
                end else begin
                    oldest = expected_events.pop_front();
                    check_field("event_res", 32'(oldest.ev), 32'(m_tuser));
                    check_field("body_char", 32'(oldest.ch), 32'(m_tdata[OFS_CHAR +: 8]));
                    check_field("position", 32'(oldest.pos), 32'(m_tdata[OFS_POS +: POS_W]));
                    check_field("field_index", 32'(oldest.fld),
                                32'(m_tdata[OFS_FIELD +: FIELD_W]));
                    check_field("received_sum", 32'(oldest.rsum), 32'(m_tdata[OFS_RSUM +: 8]));
                    check_field("computed_sum", 32'(oldest.csum), 32'(m_tdata[OFS_CSUM +: 8]));
                    check_field("good_count", oldest.good, m_tdata[OFS_GOOD +: COUNT_W]);
                    check_field("padding", 32'd0, 32'(m_tdata[RES_W-1:RES_BITS]));
                end
            end
            if (s_tvalid && s_tready) frame_byte(s_tdata);
        end
        awaited <= expected_events.size();
    end

endmodule

### test/tb_top.sv
// Stimulus and verdict for nmea_sentence_receiver; checking lives in sentence_event_checker.
// Depends on nsr_pkg, the receiver RTL and test/sentence_event_checker.sv.
module tb_top;
    import nsr_pkg::*;

    // Run ends with a failure if it is still going after this many cycles.
    localparam int unsigned CYCLE_LIMIT = 400000;
    // Long receiver hold-off used to back the block up into its input.
    localparam int unsigned HOLD_CYCLES = 80;
    // Bytes offered per register setting in the random part.
    localparam int unsigned SEG_BYTES   = 145;
    // Cycles to let the internal queue drain after the last expected event.
    localparam int unsigned DRAIN_CYCLES = 10;

    // Register settings per random segment; the last two are drawn at run time.
    // Extremes: zero limits, single-byte limits, full-width values, and a
    // fields write with bit 6 set that the register must drop.
    localparam logic [6:0] FIELD_SET [7]  = '{7'd24, 7'd63, 7'd1, 7'd0, 7'h7F, 7'd3, 7'd2};
    localparam logic [6:0] LENGTH_SET [7] = '{7'd82, 7'd127, 7'd2, 7'd127, 7'd0, 7'd1, 7'd12};

    // Short hand-made stream under reset limits: ignored bytes while waiting,
    // extreme body bytes, a dollar restarting a sentence, a comma, lowercase and
    // uppercase checksum digits, dollar and star taken as checksum digits
    // (non-hex, so a mismatch), and an empty body with checksum 00.
    localparam logic [7:0] DIRECTED [25] = '{
        8'h41, 8'hFF,
        CHAR_DOLLAR, 8'h00, 8'hFF, CHAR_DOLLAR, 8'h41, CHAR_COMMA, CHAR_STAR, 8'h36, 8'h64,
        CHAR_DOLLAR, 8'h42, CHAR_STAR, CHAR_DOLLAR, CHAR_STAR,
        CHAR_DOLLAR, CHAR_STAR, 8'h30, 8'h30,
        CHAR_DOLLAR, 8'h4B, CHAR_STAR, 8'h34, 8'h42
    };

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [RES_W-1:0]    m_tdata;
    logic [EVENT_W-1:0]  m_tuser;
    logic                cfg_we;
    logic [0:0]          cfg_addr;
    logic [6:0]          cfg_wdata;

    int unsigned mismatches;
    int unsigned awaited;
    int unsigned bytes_sent;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_req;

    nmea_sentence_receiver uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    sentence_event_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hung handshake or a lost event ends the run here.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Receiver side: random back-pressure, plus one long hold-off on request
    // while the sender keeps offering bytes, so the queue fills and s_tready drops.
    initial begin
        m_tready = 1'b0;
        hold_req = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one byte, with random idle cycles ahead of it, and hold it until accepted.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    // Drop valid and wait until every expected event has been taken, then let
    // any bytes that cause no event leave the queue as well.
    task automatic settle;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write both limit registers, fields first, then length; call only when idle.
    task automatic apply_limits(input logic [6:0] fields_val, input logic [6:0] length_val);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_MAX_FIELDS;
        cfg_wdata <= fields_val;
        @(posedge aclk);
        cfg_addr  <= REG_MAX_LENGTH;
        cfg_wdata <= length_val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Hex digit in a random letter case.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + nib;
        return (($urandom_range(1) == 0) ? 8'h41 : 8'h61) + nib - 8'd10;
    endfunction

    // Well-formed sentence with random content: mostly printable text with commas,
    // now and then raw bytes. Some are cut short before the star, some carry a
    // wrong checksum or a garbage first digit.
    task automatic send_sentence(input int unsigned body_len);
        logic [7:0] b;
        logic [7:0] xsum;
        logic [7:0] digits;
        xsum = 8'h00;
        send_byte(CHAR_DOLLAR);
        for (int i = 0; i < body_len; i++) begin
            case ($urandom_range(9))
                0, 1:    b = CHAR_COMMA;
                2:       b = 8'($urandom_range(255));
                default: b = 8'($urandom_range(8'h20, 8'h7E));
            endcase
            // keep framing bytes out of a regular body; noise supplies them
            if (b == CHAR_DOLLAR || b == CHAR_STAR) b = 8'h5F;
            xsum = xsum ^ b;
            send_byte(b);
        end
        if ($urandom_range(9) == 0) return;
        send_byte(CHAR_STAR);
        digits = ($urandom_range(5) == 0) ? 8'($urandom_range(255)) : xsum;
        if ($urandom_range(7) == 0) send_byte(8'($urandom_range(255)));
        else send_byte(hex_char(digits[7:4]));
        send_byte(hex_char(digits[3:0]));
    endtask

    initial begin
        int unsigned seg_start;
        logic [6:0]  fields_val;
        logic [6:0]  length_val;

        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        cfg_we        = 1'b0;
        cfg_addr      = REG_MAX_FIELDS;
        cfg_wdata     = 7'd0;
        bytes_sent    = 0;
        send_idle_pct = 9;
        recv_idle_pct = 73;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part under the reset limits.
        for (int i = 0; i < $size(DIRECTED); i++) send_byte(DIRECTED[i]);

        // Random part: three idling regimes, three register settings each.
        for (int seg = 0; seg < 9; seg++) begin
            send_idle_pct = (seg < 3) ? 9 : (seg < 6) ? 73 : 0;
            recv_idle_pct = (seg < 3) ? 73 : (seg < 6) ? 9 : 0;
            settle();
            if (seg < 7) begin
                fields_val = FIELD_SET[seg];
                length_val = LENGTH_SET[seg];
            end else begin
                fields_val = 7'($urandom_range(1, 8));
                length_val = 7'($urandom_range(6, 40));
            end
            apply_limits(fields_val, length_val);
            // long receiver stall while the sender streams without gaps
            if (seg == 6) hold_req = 1'b1;
            seg_start = bytes_sent;
            while (bytes_sent - seg_start < SEG_BYTES) begin
                if ($urandom_range(9) == 0) begin
                    // noise: stray bytes between sentences or inside a cut-off one
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
                end else if ($urandom_range(14) == 0) begin
                    send_sentence($urandom_range(130));
                end else begin
                    send_sentence($urandom_range(12));
                end
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### filelist.f
design/nsr_pkg.sv
design/nsr_front.sv
design/nsr_queue.sv
design/nsr_framer.sv
design/nmea_sentence_receiver.sv
test/sentence_event_checker.sv
test/tb_top.sv
